>>> rtl/core/matrix_vector_multiply_defines.svh
`ifndef MATRIX_VECTOR_MULTIPLY_DEFINES_SVH
`define MATRIX_VECTOR_MULTIPLY_DEFINES_SVH
`ifndef SYNTHESIS
`define MVM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define MVM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MVM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define MVM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/core/mvm_pkg.sv
`default_nettype none

package mvm_pkg;

  localparam int VALUE_W   = 16;
  localparam int SEL_W     = 4;
  localparam int PROD_W    = 32;
  localparam int ACC_W     = 36;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int COUNT_W   = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;
  localparam logic [CFG_W-1:0]   CFG_RESET = 5'd16;

  localparam logic MODE_WEIGHT  = 1'b0;
  localparam logic MODE_ELEMENT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 2'd1;

  typedef struct packed {
    logic mul_en;
    logic clear;
  } mac_ctrl_t;

  typedef struct packed {
    logic busy;
  } mac_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/mvm_in_if.sv
`default_nettype none

interface mvm_in_if;
  logic                               valid;
  logic                               ready;
  logic                               mode;
  logic        [mvm_pkg::SEL_W-1:0]   row_sel;
  logic        [mvm_pkg::SEL_W-1:0]   col_sel;
  logic signed [mvm_pkg::VALUE_W-1:0] value;
  logic                               last;

  modport source (output valid, mode, row_sel, col_sel, value, last, input ready);
  modport sink   (input valid, mode, row_sel, col_sel, value, last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/mvm_out_if.sv
`default_nettype none

interface mvm_out_if;
  logic                             valid;
  logic                             ready;
  logic        [mvm_pkg::SEL_W-1:0] row_index;
  logic signed [mvm_pkg::ACC_W-1:0] dot_sum;
  logic                             length_error;
  logic                             final_result;

  modport source (output valid, row_index, dot_sum, length_error, final_result, input ready);
  modport sink   (input valid, row_index, dot_sum, length_error, final_result, output ready);
endinterface

`default_nettype wire

>>> rtl/core/mvm_cfg_if.sv
`default_nettype none

interface mvm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mvm_pkg::CFG_IDX_W-1:0]   index;
  logic [mvm_pkg::CFG_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/mvm_weight_mem.sv
`default_nettype none

module mvm_weight_mem #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem_r [2**ADDR_W];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/core/mvm_mac.sv
`default_nettype none

module mvm_mac #(
  parameter int  MAX_ROWS = 16,
  localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mvm_pkg::mac_ctrl_t                 ctrl,
  input  logic [ROW_W-1:0]                   mul_row,
  input  logic [ROW_W-1:0]                   rd_row,
  input  logic signed [mvm_pkg::VALUE_W-1:0] weight,
  input  logic signed [mvm_pkg::VALUE_W-1:0] element,
  output mvm_pkg::mac_stat_t                 stat,
  output logic [mvm_pkg::ACC_W-1:0]          acc_rd
);

  localparam int EXT_W = mvm_pkg::ACC_W - mvm_pkg::PROD_W;

  logic signed [mvm_pkg::PROD_W-1:0] prod_r;
  logic                              prod_vld_r;
  logic [ROW_W-1:0]                  prod_row_r;
  logic [mvm_pkg::ACC_W-1:0]         acc_r [MAX_ROWS];
  logic [ROW_W-1:0]                  acc_idx;
  logic [mvm_pkg::ACC_W-1:0]         acc_sum;

  // accumulate and emit never overlap, so one read index serves both
  assign acc_idx = prod_vld_r ? prod_row_r : rd_row;
  assign acc_rd  = acc_r[acc_idx];
  assign acc_sum = acc_rd + {{EXT_W{prod_r[mvm_pkg::PROD_W-1]}}, prod_r};
  assign stat.busy = prod_vld_r;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r     <= weight * element;
      prod_row_r <= mul_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      for (int i = 0; i < MAX_ROWS; i++) begin
        acc_r[i] <= '0;
      end
    end else begin
      prod_vld_r <= ctrl.mul_en;
      if (ctrl.clear) begin
        for (int i = 0; i < MAX_ROWS; i++) begin
          acc_r[i] <= '0;
        end
      end else if (prod_vld_r) begin
        acc_r[prod_row_r] <= acc_sum;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/mvm_ctrl.sv
`default_nettype none
`include "matrix_vector_multiply_defines.svh"

module mvm_ctrl #(
  parameter int  MAX_ROWS = 16,
  parameter int  MAX_COLS = 16,
  localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  mvm_in_if.sink                              in_ch,
  mvm_out_if.source                           out_ch,
  input  logic [mvm_pkg::CFG_W-1:0]           rows_in_use,
  input  logic [mvm_pkg::CFG_W-1:0]           cols_in_use,
  output logic                                mem_we,
  output logic [ROW_W+COL_W-1:0]              mem_waddr,
  output logic [mvm_pkg::VALUE_W-1:0]         mem_wdata,
  output logic [ROW_W+COL_W-1:0]              mem_raddr,
  output mvm_pkg::mac_ctrl_t                  mac_ctrl,
  output logic [ROW_W-1:0]                    mul_row,
  output logic [ROW_W-1:0]                    rd_row,
  output logic signed [mvm_pkg::VALUE_W-1:0]  element,
  input  mvm_pkg::mac_stat_t                  mac_stat,
  input  logic [mvm_pkg::ACC_W-1:0]           acc_rd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACC,
    S_EMIT
  } state_t;

  state_t                             state_r;
  logic [mvm_pkg::COUNT_W-1:0]        count_r;
  logic [COL_W-1:0]                   col_r;
  logic signed [mvm_pkg::VALUE_W-1:0] value_r;
  logic                               last_r;
  logic [ROW_W-1:0]                   iss_r;
  logic                               iss_act_r;
  logic                               rd_vld_r;
  logic [ROW_W-1:0]                   rd_row_r;
  logic                               err_r;
  logic [ROW_W-1:0]                   em_r;
  logic                               out_valid_r;
  logic [mvm_pkg::SEL_W-1:0]          out_row_r;
  logic [mvm_pkg::ACC_W-1:0]          out_sum_r;
  logic                               out_err_r;
  logic                               out_fin_r;

  logic                               in_xfer;
  logic                               wr_hit;
  logic                               elem_xfer;
  logic                               col_ok;
  logic [mvm_pkg::COUNT_W-1:0]        count_inc;
  logic                               len_bad;
  logic                               drained;
  logic                               out_free;
  logic                               load;
  logic                               em_final;
  logic                               err_fmt_ok;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign wr_hit      = in_xfer && (in_ch.mode == mvm_pkg::MODE_WEIGHT)
                       && (int'(in_ch.row_sel) < MAX_ROWS)
                       && (int'(in_ch.col_sel) < MAX_COLS);
  assign elem_xfer   = in_xfer && (in_ch.mode == mvm_pkg::MODE_ELEMENT);

  assign mem_we    = wr_hit;
  assign mem_waddr = {ROW_W'(in_ch.row_sel), COL_W'(in_ch.col_sel)};
  assign mem_wdata = in_ch.value;
  assign mem_raddr = {iss_r, col_r};

  assign col_ok    = int'(count_r) < MAX_COLS;
  assign count_inc = (count_r == mvm_pkg::COUNT_MAX) ? count_r
                   : count_r + mvm_pkg::COUNT_W'(1);
  assign len_bad   = (count_r != cols_in_use) || (int'(count_r) > MAX_COLS);
  assign drained   = !iss_act_r && !rd_vld_r && !mac_stat.busy;

  assign out_free = !out_valid_r || out_ch.ready;
  assign load     = (state_r == S_EMIT) && out_free;
  // row count of zero acts as one, above MAX_ROWS as MAX_ROWS
  assign em_final = err_r || (int'(em_r) + 1 >= int'(rows_in_use))
                    || (int'(em_r) + 1 >= MAX_ROWS);

  assign mac_ctrl.mul_en = rd_vld_r;
  assign mac_ctrl.clear  = load && em_final;
  assign mul_row         = rd_row_r;
  assign rd_row          = em_r;
  assign element         = value_r;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.row_index    = out_row_r;
  assign out_ch.dot_sum      = out_sum_r;
  assign out_ch.length_error = out_err_r;
  assign out_ch.final_result = out_fin_r;

  assign err_fmt_ok = out_fin_r && (out_row_r == '0) && (out_sum_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      iss_act_r   <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      em_r        <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (elem_xfer) begin
            value_r   <= in_ch.value;
            last_r    <= in_ch.last;
            col_r     <= COL_W'(count_r);
            count_r   <= count_inc;
            iss_r     <= '0;
            iss_act_r <= col_ok;
            state_r   <= S_ACC;
          end
        end
        S_ACC: begin
          rd_vld_r <= iss_act_r;
          rd_row_r <= iss_r;
          if (iss_act_r) begin
            if (int'(iss_r) == MAX_ROWS - 1) begin
              iss_act_r <= 1'b0;
            end else begin
              iss_r <= iss_r + ROW_W'(1);
            end
          end
          if (drained) begin
            if (last_r) begin
              err_r   <= len_bad;
              em_r    <= '0;
              state_r <= S_EMIT;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_EMIT: begin
          if (load) begin
            out_row_r <= err_r ? '0 : mvm_pkg::SEL_W'(em_r);
            out_sum_r <= err_r ? '0 : acc_rd;
            out_err_r <= err_r;
            out_fin_r <= em_final;
            if (em_final) begin
              count_r <= '0;
              em_r    <= '0;
              state_r <= S_IDLE;
            end else begin
              em_r <= em_r + ROW_W'(1);
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `MVM_ASSERT_IMP(a_idle_drained, clk, rst_n, state_r == S_IDLE, drained, "busy while idle")
  `MVM_ASSERT_IMP(a_clear_quiet, clk, rst_n, mac_ctrl.clear, !mac_stat.busy, "clear while busy")
  `MVM_ASSERT_IMP(a_err_result, clk, rst_n, out_valid_r && out_err_r, err_fmt_ok, "bad error")
  `MVM_ASSERT_NEXT(a_clear_final, clk, rst_n, mac_ctrl.clear, out_valid_r && out_fin_r, "no final")

endmodule

`default_nettype wire

>>> rtl/core/matrix_vector_multiply.sv
// Weight write: accepted every cycle while idle.
// Vector element: one row per cycle through the shared multiply-accumulate
// unit behind the registered weight memory read port.
// Last element: rows then emitted one per cycle unless the output stalls.
// Reset (rst_n low, synchronous): accumulators, element count and output clear,
// rows_in_use and cols_in_use return to 16, weights stay undefined until written.
`default_nettype none

module matrix_vector_multiply #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  mvm_in_if.sink     in_ch,
  mvm_out_if.source  out_ch,
  mvm_cfg_if.sink    cfg_ch
);

  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ADDR_W = ROW_W + COL_W;

  logic [mvm_pkg::CFG_W-1:0]          rows_r;
  logic [mvm_pkg::CFG_W-1:0]          cols_r;
  logic                               mem_we;
  logic [ADDR_W-1:0]                  mem_waddr;
  logic [mvm_pkg::VALUE_W-1:0]        mem_wdata;
  logic [ADDR_W-1:0]                  mem_raddr;
  logic [mvm_pkg::VALUE_W-1:0]        mem_rdata;
  mvm_pkg::mac_ctrl_t                 mac_ctrl;
  mvm_pkg::mac_stat_t                 mac_stat;
  logic [ROW_W-1:0]                   mul_row;
  logic [ROW_W-1:0]                   rd_row;
  logic signed [mvm_pkg::VALUE_W-1:0] element;
  logic [mvm_pkg::ACC_W-1:0]          acc_rd;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= mvm_pkg::CFG_RESET;
      cols_r <= mvm_pkg::CFG_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        mvm_pkg::REG_ROWS_IN_USE: rows_r <= cfg_ch.data;
        mvm_pkg::REG_COLS_IN_USE: cols_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  mvm_weight_mem #(
    .ADDR_W (ADDR_W),
    .DATA_W (mvm_pkg::VALUE_W)
  ) u_weight_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mvm_mac #(
    .MAX_ROWS (MAX_ROWS)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (mac_ctrl),
    .mul_row (mul_row),
    .rd_row  (rd_row),
    .weight  ($signed(mem_rdata)),
    .element (element),
    .stat    (mac_stat),
    .acc_rd  (acc_rd)
  );

  mvm_ctrl #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .rows_in_use (rows_r),
    .cols_in_use (cols_r),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mac_ctrl    (mac_ctrl),
    .mul_row     (mul_row),
    .rd_row      (rd_row),
    .element     (element),
    .mac_stat    (mac_stat),
    .acc_rd      (acc_rd)
  );

endmodule

`default_nettype wire

>>> verif/tb_matrix_vector_multiply.sv
`timescale 1ns / 1ps

module tb_matrix_vector_multiply;

  localparam int NUM_ROWS    = 16;
  localparam int NUM_COLS    = 16;
  localparam int FULL_ROWS   = 4;
  localparam int FULL_COLS   = 4;
  localparam int RAND_ITEMS  = 84;
  localparam int SETTLE_CYC  = 48;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic                               mode;
    logic [mvm_pkg::SEL_W-1:0]          row_sel;
    logic [mvm_pkg::SEL_W-1:0]          col_sel;
    logic signed [mvm_pkg::VALUE_W-1:0] value;
    logic                               last;
  } mvm_item_t;

  typedef struct {
    logic [mvm_pkg::SEL_W-1:0]        row_index;
    logic signed [mvm_pkg::ACC_W-1:0] dot_sum;
    logic                             length_error;
    logic                             final_result;
  } sum_result_t;

  typedef enum logic {STEP_ITEM, STEP_CFG} step_kind_t;

  typedef struct {
    step_kind_t                    kind;
    mvm_item_t                     item;
    logic [mvm_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [mvm_pkg::CFG_W-1:0]     reg_val;
    logic                          typed;
    sum_result_t                   want;
  } dir_step_t;

  logic clk;
  logic rst_n;

  mvm_in_if  in_ch();
  mvm_out_if out_ch();
  mvm_cfg_if cfg_ch();

  matrix_vector_multiply i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // mirror of the block state
  logic signed [mvm_pkg::VALUE_W-1:0] wt_mem [NUM_ROWS][NUM_COLS];
  logic signed [mvm_pkg::ACC_W-1:0]   row_acc [NUM_ROWS];
  logic [mvm_pkg::COUNT_W-1:0]        elem_cnt;
  logic [mvm_pkg::CFG_W-1:0]          rows_cfg;
  logic [mvm_pkg::CFG_W-1:0]          cols_cfg;

  sum_result_t pred_buf [NUM_ROWS];
  int          pred_n;
  sum_result_t pending_sums [$];
  dir_step_t   dir_steps [$];
  sum_result_t no_sum;
  sum_result_t len_err;

  int  fail_cnt;
  int  cycle_cnt;
  bit  burst;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
               pending_sums.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void queue_sum(sum_result_t s);
    pending_sums.insert(pending_sums.size(), s);
  endfunction

  function automatic void add_step(dir_step_t s);
    dir_steps.insert(dir_steps.size(), s);
  endfunction

  function automatic void predict_item(mvm_item_t it);
    int nrows;
    pred_n = 0;
    if (it.mode == mvm_pkg::MODE_WEIGHT) begin
      wt_mem[it.row_sel][it.col_sel] = it.value;
    end else begin
      if (elem_cnt < NUM_COLS) begin
        for (int r = 0; r < NUM_ROWS; r++) begin
          row_acc[r] = row_acc[r] + wt_mem[r][elem_cnt] * it.value;
        end
      end
      if (elem_cnt != mvm_pkg::COUNT_MAX) elem_cnt++;
      if (it.last) begin
        if (elem_cnt != cols_cfg || elem_cnt > NUM_COLS) begin
          pred_buf[0] = len_err;
          pred_n = 1;
        end else begin
          nrows = (rows_cfg == 0) ? 1 : (rows_cfg > NUM_ROWS) ? NUM_ROWS : int'(rows_cfg);
          for (int r = 0; r < nrows; r++) begin
            pred_buf[r] = '{mvm_pkg::SEL_W'(r), row_acc[r], 1'b0, (r == nrows - 1)};
          end
          pred_n = nrows;
        end
        for (int r = 0; r < NUM_ROWS; r++) row_acc[r] = '0;
        elem_cnt = '0;
      end
    end
  endfunction

  function automatic logic signed [mvm_pkg::VALUE_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: begin
        return 16'sh8000;
      end
      1: begin
        return 16'sh7FFF;
      end
      2: begin
        return '0;
      end
      default: begin
        return mvm_pkg::VALUE_W'($urandom);
      end
    endcase
  endfunction

  function automatic logic [mvm_pkg::CFG_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0: begin
        return mvm_pkg::CFG_W'(1);
      end
      1: begin
        return mvm_pkg::CFG_W'(NUM_ROWS);
      end
      2: begin
        return ($urandom_range(0, 1) == 0) ? mvm_pkg::CFG_W'(0)
                                           : mvm_pkg::CFG_W'($urandom_range(17, 31));
      end
      default: begin
        return mvm_pkg::CFG_W'($urandom_range(1, 6));
      end
    endcase
  endfunction

  function automatic mvm_item_t weight_item(int r, int c,
                                            logic signed [mvm_pkg::VALUE_W-1:0] v,
                                            logic l);
    weight_item = '{mvm_pkg::MODE_WEIGHT, mvm_pkg::SEL_W'(r), mvm_pkg::SEL_W'(c), v, l};
  endfunction

  function automatic mvm_item_t elem_item(logic signed [mvm_pkg::VALUE_W-1:0] v, logic l);
    elem_item = '{mvm_pkg::MODE_ELEMENT, mvm_pkg::SEL_W'($urandom),
                  mvm_pkg::SEL_W'($urandom), v, l};
  endfunction

  function automatic dir_step_t item_step(mvm_item_t it);
    item_step = '{STEP_ITEM, it, '0, '0, 1'b0, no_sum};
  endfunction

  function automatic dir_step_t typed_step(mvm_item_t it, sum_result_t want);
    typed_step = '{STEP_ITEM, it, '0, '0, 1'b1, want};
  endfunction

  function automatic dir_step_t cfg_step(logic [mvm_pkg::CFG_IDX_W-1:0] idx,
                                         logic [mvm_pkg::CFG_W-1:0] val);
    cfg_step = '{STEP_CFG, elem_item('0, 1'b0), idx, val, 1'b0, no_sum};
  endfunction

  task automatic send_item(mvm_item_t it, logic typed, sum_result_t want);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= it.mode;
    in_ch.row_sel <= it.row_sel;
    in_ch.col_sel <= it.col_sel;
    in_ch.value   <= it.value;
    in_ch.last    <= it.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_item(it);
    if (typed) begin
      queue_sum(want);
    end else begin
      for (int k = 0; k < pred_n; k++) queue_sum(pred_buf[k]);
    end
  endtask

  // registers change only once the block has drained
  task automatic write_reg(logic [mvm_pkg::CFG_IDX_W-1:0] idx,
                           logic [mvm_pkg::CFG_W-1:0] val);
    in_ch.valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == mvm_pkg::REG_ROWS_IN_USE) rows_cfg = val;
    else cols_cfg = val;
  endtask

  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    sum_result_t got;
    sum_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.row_index, out_ch.dot_sum, out_ch.length_error, out_ch.final_result};
      if (pending_sums.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS) begin
          $display("unexpected transfer: row %0d sum %0d err %0b final %0b",
                   got.row_index, got.dot_sum, got.length_error, got.final_result);
        end
      end else begin
        want = pending_sums.pop_front();
        if (got.row_index !== want.row_index || got.dot_sum !== want.dot_sum ||
            got.length_error !== want.length_error ||
            got.final_result !== want.final_result) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS) begin
            $display("mismatch: exp row %0d sum %0d err %0b final %0b",
                     want.row_index, want.dot_sum, want.length_error, want.final_result);
            $display("          got row %0d sum %0d err %0b final %0b",
                     got.row_index, got.dot_sum, got.length_error, got.final_result);
          end
        end
      end
    end
  end

  initial begin : stimulus
    int                        sent;
    int                        shape;
    int                        vec_len;
    int                        eff_rows;
    logic [mvm_pkg::CFG_W-1:0] rows_pick;
    logic [mvm_pkg::CFG_W-1:0] cols_pick;

    fail_cnt  = 0;
    cycle_cnt = 0;
    burst     = 1'b0;
    no_sum    = '{'0, '0, 1'b0, 1'b0};
    len_err   = '{'0, '0, 1'b1, 1'b1};
    for (int r = 0; r < NUM_ROWS; r++) begin
      row_acc[r] = '0;
      for (int c = 0; c < NUM_COLS; c++) wt_mem[r][c] = '0;
    end
    elem_cnt = '0;
    rows_cfg = mvm_pkg::CFG_RESET;
    cols_cfg = mvm_pkg::CFG_RESET;

    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.mode    <= mvm_pkg::MODE_WEIGHT;
    in_ch.row_sel <= '0;
    in_ch.col_sel <= '0;
    in_ch.value   <= '0;
    in_ch.last    <= 1'b0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= mvm_pkg::REG_ROWS_IN_USE;
    cfg_ch.data   <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first FULL_COLS columns of every row and every column of the first FULL_ROWS
    // rows; sizes are drawn so that emitted sums stay inside this region
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        if (r < FULL_ROWS || c < FULL_COLS) begin
          send_item(weight_item(r, c, rand_word(), 1'($urandom_range(0, 1))), 1'b0, no_sum);
        end
      end
    end

    // short vector under the reset sizes
    add_step(typed_step(elem_item(16'sd7, 1'b1), len_err));
    add_step(cfg_step(mvm_pkg::REG_ROWS_IN_USE, 5'd1));
    add_step(cfg_step(mvm_pkg::REG_COLS_IN_USE, 5'd1));
    add_step(item_step(weight_item(0, 0, 16'sh8000, 1'b0)));
    add_step(typed_step(elem_item(16'sh8000, 1'b1),
                        '{'0, 36'sd1073741824, 1'b0, 1'b1}));
    // last is ignored on a weight transfer
    add_step(item_step(weight_item(0, 0, 16'sh7FFF, 1'b1)));
    add_step(typed_step(elem_item(16'sh7FFF, 1'b1),
                        '{'0, 36'sd1073676289, 1'b0, 1'b1}));
    add_step(item_step(elem_item(16'sd0, 1'b0)));
    add_step(typed_step(elem_item(16'sd1, 1'b1), len_err));
    // zero sizes
    add_step(cfg_step(mvm_pkg::REG_ROWS_IN_USE, 5'd0));
    add_step(cfg_step(mvm_pkg::REG_COLS_IN_USE, 5'd0));
    add_step(typed_step(elem_item(16'sd5, 1'b1), len_err));
    // row count above the matrix, weight rewritten mid-vector
    add_step(cfg_step(mvm_pkg::REG_ROWS_IN_USE, 5'd31));
    add_step(cfg_step(mvm_pkg::REG_COLS_IN_USE, 5'd3));
    add_step(item_step(elem_item(16'sh8000, 1'b0)));
    add_step(item_step(weight_item(2, 2, -16'sd1, 1'b0)));
    add_step(item_step(elem_item(16'sh7FFF, 1'b0)));
    add_step(item_step(elem_item(16'sd1, 1'b1)));
    add_step(cfg_step(mvm_pkg::REG_ROWS_IN_USE, 5'd16));
    add_step(cfg_step(mvm_pkg::REG_COLS_IN_USE, 5'd2));
    add_step(item_step(elem_item(16'sh8000, 1'b0)));
    add_step(item_step(elem_item(16'sh8000, 1'b1)));

    foreach (dir_steps[i]) begin
      if (dir_steps[i].kind == STEP_CFG) begin
        write_reg(dir_steps[i].reg_idx, dir_steps[i].reg_val);
      end else begin
        send_item(dir_steps[i].item, dir_steps[i].typed, dir_steps[i].want);
      end
    end

    sent = 0;
    while (sent < RAND_ITEMS) begin
      burst     = ($urandom_range(0, 3) == 0);
      rows_pick = pick_size();
      cols_pick = pick_size();
      eff_rows  = (rows_pick == 0) ? 1 : (rows_pick > NUM_ROWS) ? NUM_ROWS : int'(rows_pick);
      if (eff_rows > FULL_ROWS && cols_pick > FULL_COLS && cols_pick <= NUM_COLS) begin
        cols_pick = mvm_pkg::CFG_W'($urandom_range(1, FULL_COLS));
      end
      write_reg(mvm_pkg::REG_ROWS_IN_USE, rows_pick);
      write_reg(mvm_pkg::REG_COLS_IN_USE, cols_pick);
      repeat ($urandom_range(1, 4)) begin
        shape   = $urandom_range(0, 19);
        vec_len = (cols_cfg == 0) ? 1 : int'(cols_cfg);
        if (shape == 0) begin
          // overruns the saturating element count
          vec_len = 32 + $urandom_range(0, 3);
        end else if (shape < 4) begin
          vec_len = $urandom_range(1, 18);
        end else if (shape == 4) begin
          vec_len = 0;
          repeat ($urandom_range(1, 4)) begin
            send_item(weight_item($urandom, $urandom, rand_word(), 1'($urandom_range(0, 1))),
                      1'b0, no_sum);
            sent++;
          end
        end
        for (int k = 0; k < vec_len; k++) begin
          if ($urandom_range(0, 5) == 0) begin
            send_item(weight_item($urandom, $urandom, rand_word(), 1'($urandom_range(0, 1))),
                      1'b0, no_sum);
            sent++;
          end
          send_item(elem_item(rand_word(), (k == vec_len - 1)), 1'b0, no_sum);
          sent++;
        end
      end
    end

    in_ch.valid <= 1'b0;
    burst = 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (fail_cnt == 0 && pending_sums.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
